// ===== design/vector2_normalize_defines.svh =====
// assertion macros for the vector normalizer
`ifndef VECTOR2_NORMALIZE_DEFINES_SVH
`define VECTOR2_NORMALIZE_DEFINES_SVH

// same-cycle implication under synchronous reset
`define V2N_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vector2_normalize: same-cycle check failed");

// next-cycle implication under synchronous reset
`define V2N_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vector2_normalize: next-cycle check failed");

`endif

// ===== design/v2n_pkg.sv =====
// types, widths and the per-bit search step of the vector normalizer
package v2n_pkg;

  localparam int unsigned COMP_W    = 16;  // input component width
  localparam int unsigned MAG_W     = 17;  // magnitude, holds 32768
  localparam int unsigned SQ_W      = 31;  // square of a magnitude, up to 2^30
  localparam int unsigned SUM_W     = 32;  // x^2 + y^2, up to 2^31
  localparam int unsigned FRAC_BITS = 14;  // Q2.14 fraction
  localparam int unsigned RES_W     = 59;  // residual, bound m^2 * 2^28 up to 2^58
  localparam int unsigned QS_W      = 47;  // q * S
  localparam int unsigned Q_W       = 15;  // result magnitude, up to 16384
  localparam int unsigned D_W       = 63;  // trial increment of q^2 * S

  // one lane of the digit search: residual, q*S and q
  typedef struct packed {
    logic [RES_W-1:0] res;
    logic [QS_W-1:0]  qs;
    logic [Q_W-1:0]   q;
  } lane_t;

  // side information traveling with an item
  typedef struct packed {
    logic zero;
    logic neg_x;
    logic neg_y;
  } side_t;

  // try bit b of q: (q + 2^b)^2 S - q^2 S = q S 2^(b+1) + S 2^(2b)
  function automatic lane_t lane_step(lane_t cur, logic [SUM_W-1:0] s, int unsigned b);
    logic [D_W-1:0] dlt;
    logic [D_W-1:0] res_ext;
    lane_t          nxt;
    dlt     = (D_W'(cur.qs) << (b + 1)) + (D_W'(s) << (2 * b));
    res_ext = D_W'(cur.res);
    nxt     = cur;
    if (dlt <= res_ext) begin
      nxt.res = cur.res - RES_W'(dlt);
      nxt.qs  = cur.qs + (QS_W'(s) << b);
      nxt.q   = cur.q | (Q_W'(1) << b);
    end
    return nxt;
  endfunction

endpackage

// ===== design/vector2_normalize.sv =====
// vector2_normalize: exact Q2.14 unit vector of a signed 16-bit 2D vector
// throughput: one vector per cycle while in_stall is low
// 3 setup stages, 15 bit-search stages and an output register
// each search stage settles one bit of both results with one wide add and compare
// stall on the output holds the whole pipeline; in_stall follows a held full output
// reset clears all valid bits; payload registers are not reset
`include "vector2_normalize_defines.svh"

module vector2_normalize (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_x_component,
  input  logic signed [15:0] in_y_component,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_unit_x,
  output logic signed [15:0] out_unit_y,
  output logic               out_zero_length
);

  localparam int unsigned NSTG = v2n_pkg::Q_W;

  logic adv;

  // stage 1: magnitudes and signs
  logic                       s1_vld_r;
  logic [v2n_pkg::MAG_W-1:0]  s1_ax_r, s1_ay_r;
  logic                       s1_nx_r, s1_ny_r;
  logic [v2n_pkg::MAG_W-1:0]  s1_ax_nxt, s1_ay_nxt;

  // stage 2: squares
  logic                       s2_vld_r;
  logic [v2n_pkg::SQ_W-1:0]   s2_ax2_r, s2_ay2_r;
  logic                       s2_nx_r, s2_ny_r;
  logic [2*v2n_pkg::MAG_W-1:0] sqx_full, sqy_full;

  // search pipeline, index 0 is the setup output
  logic                       vld_r [0:NSTG];
  v2n_pkg::lane_t             lx_r  [0:NSTG];
  v2n_pkg::lane_t             ly_r  [0:NSTG];
  logic [v2n_pkg::SUM_W-1:0]  s_r   [0:NSTG];
  v2n_pkg::side_t             sd_r  [0:NSTG];
  logic [v2n_pkg::SUM_W-1:0]  sum_nxt;

  // output register
  logic                       ov_r;
  logic signed [15:0]         ox_r, oy_r;
  logic                       oz_r;
  logic signed [15:0]         ox_nxt, oy_nxt;

  // pipeline moves unless a held result blocks it
  assign in_stall = ov_r & out_stall;
  assign adv      = ~in_stall;

  // magnitude of two's complement, -32768 gives 32768
  always_comb begin
    s1_ax_nxt = in_x_component[15] ? (17'h10000 - {1'b0, in_x_component})
                                   : {1'b0, in_x_component};
    s1_ay_nxt = in_y_component[15] ? (17'h10000 - {1'b0, in_y_component})
                                   : {1'b0, in_y_component};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
    end
    if (adv) begin
      s1_ax_r <= s1_ax_nxt;
      s1_ay_r <= s1_ay_nxt;
      s1_nx_r <= in_x_component[15];
      s1_ny_r <= in_y_component[15];
    end
  end

  // squares of the magnitudes
  always_comb begin
    sqx_full = s1_ax_r * s1_ax_r;
    sqy_full = s1_ay_r * s1_ay_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
    if (adv) begin
      s2_ax2_r <= sqx_full[v2n_pkg::SQ_W-1:0];
      s2_ay2_r <= sqy_full[v2n_pkg::SQ_W-1:0];
      s2_nx_r  <= s1_nx_r;
      s2_ny_r  <= s1_ny_r;
    end
  end

  // squared length and the search bounds m^2 * 2^28
  assign sum_nxt = v2n_pkg::SUM_W'(s2_ax2_r) + v2n_pkg::SUM_W'(s2_ay2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= s2_vld_r;
    end
    if (adv) begin
      s_r[0]        <= sum_nxt;
      lx_r[0].res   <= v2n_pkg::RES_W'(s2_ax2_r) << (2 * v2n_pkg::FRAC_BITS);
      lx_r[0].qs    <= '0;
      lx_r[0].q     <= '0;
      ly_r[0].res   <= v2n_pkg::RES_W'(s2_ay2_r) << (2 * v2n_pkg::FRAC_BITS);
      ly_r[0].qs    <= '0;
      ly_r[0].q     <= '0;
      sd_r[0].zero  <= (sum_nxt == '0);
      sd_r[0].neg_x <= s2_nx_r;
      sd_r[0].neg_y <= s2_ny_r;
    end
  end

  // bit search, most significant bit first, one bit per stage
  for (genvar k = 0; k < NSTG; k++) begin : g_srch
    v2n_pkg::lane_t lx_nxt, ly_nxt;

    always_comb begin
      lx_nxt = v2n_pkg::lane_step(lx_r[k], s_r[k], NSTG - 1 - k);
      ly_nxt = v2n_pkg::lane_step(ly_r[k], s_r[k], NSTG - 1 - k);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (adv) begin
        lx_r[k+1] <= lx_nxt;
        ly_r[k+1] <= ly_nxt;
        s_r[k+1]  <= s_r[k];
        sd_r[k+1] <= sd_r[k];
      end
    end
  end

  // apply signs, zero vector forces zero outputs
  always_comb begin
    ox_nxt = $signed({1'b0, lx_r[NSTG].q});
    oy_nxt = $signed({1'b0, ly_r[NSTG].q});
    if (sd_r[NSTG].neg_x) begin
      ox_nxt = -ox_nxt;
    end
    if (sd_r[NSTG].neg_y) begin
      oy_nxt = -oy_nxt;
    end
    if (sd_r[NSTG].zero) begin
      ox_nxt = '0;
      oy_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= vld_r[NSTG];
    end
    if (adv) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      oz_r <= sd_r[NSTG].zero;
    end
  end

  assign out_valid       = ov_r;
  assign out_unit_x      = ox_r;
  assign out_unit_y      = oy_r;
  assign out_zero_length = oz_r;

  // zero vector gives zero components
  `V2N_ASSERT_NOW(a_zero_out, clk, rst_n, ov_r && oz_r, (ox_r == 16'sd0) && (oy_r == 16'sd0))
  // a nonzero vector never normalizes to all zero
  `V2N_ASSERT_NOW(a_nonzero_out, clk, rst_n, ov_r && !oz_r, (ox_r != 16'sd0) || (oy_r != 16'sd0))
  // components stay within the unit range
  `V2N_ASSERT_NOW(a_range_out, clk, rst_n, ov_r, (ox_r >= -16'sd16384) && (ox_r <= 16'sd16384) && (oy_r >= -16'sd16384) && (oy_r <= 16'sd16384))
  // a finished search item reaches the output register
  `V2N_ASSERT_NEXT(a_last_moves, clk, rst_n, adv && vld_r[NSTG], ov_r)

endmodule

// ===== test/vector2_normalize_tb.sv =====
// testbench for vector2_normalize: directed table plus random vectors, exact unit-vector checks
`timescale 1ns / 100ps

module vector2_normalize_tb;

  localparam int HALF_PERIOD = 5;
  localparam int N_DIR       = 22;
  localparam int N_RAND      = 400;
  localparam int PHASE_LEN   = 130;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 25;
  localparam int MAX_REPORTS = 10;

  // one expected or observed result transfer
  typedef struct packed {
    logic signed [v2n_pkg::COMP_W-1:0] ux;
    logic signed [v2n_pkg::COMP_W-1:0] uy;
    logic                              zero;
  } unit_result_t;

  // one row of the directed table; known rows carry their result
  typedef struct packed {
    logic signed [v2n_pkg::COMP_W-1:0] x;
    logic signed [v2n_pkg::COMP_W-1:0] y;
    logic                              known;
    logic signed [v2n_pkg::COMP_W-1:0] ux;
    logic signed [v2n_pkg::COMP_W-1:0] uy;
    logic                              zero;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{16'sd0,      16'sd0,      1'b1, 16'sd0,      16'sd0,      1'b1},
    '{16'sd32767,  16'sd0,      1'b1, 16'sd16384,  16'sd0,      1'b0},
    '{16'sh8000,   16'sd0,      1'b1, -16'sd16384, 16'sd0,      1'b0},
    '{16'sd0,      16'sd32767,  1'b1, 16'sd0,      16'sd16384,  1'b0},
    '{16'sd0,      16'sh8000,   1'b1, 16'sd0,      -16'sd16384, 1'b0},
    '{16'sd1,      16'sd0,      1'b1, 16'sd16384,  16'sd0,      1'b0},
    '{16'sd0,      -16'sd1,     1'b1, 16'sd0,      -16'sd16384, 1'b0},
    '{-16'sd1,     16'sd0,      1'b1, -16'sd16384, 16'sd0,      1'b0},
    '{16'sh8000,   16'sh8000,   1'b0, 16'sd0,      16'sd0,      1'b0},
    '{16'sd32767,  16'sd32767,  1'b0, 16'sd0,      16'sd0,      1'b0},
    '{16'sd32767,  16'sh8000,   1'b0, 16'sd0,      16'sd0,      1'b0},
    '{16'sh8000,   16'sd32767,  1'b0, 16'sd0,      16'sd0,      1'b0},
    '{16'sd1,      16'sd1,      1'b0, 16'sd0,      16'sd0,      1'b0},
    '{-16'sd1,     16'sd1,      1'b0, 16'sd0,      16'sd0,      1'b0},
    '{16'sd3,      16'sd4,      1'b0, 16'sd0,      16'sd0,      1'b0},
    '{-16'sd3,     -16'sd4,     1'b0, 16'sd0,      16'sd0,      1'b0},
    '{16'sd1,      16'sh8000,   1'b0, 16'sd0,      16'sd0,      1'b0},
    '{16'sh8000,   16'sd1,      1'b0, 16'sd0,      16'sd0,      1'b0},
    '{16'sd12345,  -16'sd6789,  1'b0, 16'sd0,      16'sd0,      1'b0},
    '{16'sd0,      16'sd0,      1'b1, 16'sd0,      16'sd0,      1'b1},
    '{-16'sd21846, 16'sd5461,   1'b0, 16'sd0,      16'sd0,      1'b0},
    '{16'sd21845,  -16'sd21846, 1'b0, 16'sd0,      16'sd0,      1'b0}
  };

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic signed [v2n_pkg::COMP_W-1:0] in_x_component;
  logic signed [v2n_pkg::COMP_W-1:0] in_y_component;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [v2n_pkg::COMP_W-1:0] out_unit_x;
  logic signed [v2n_pkg::COMP_W-1:0] out_unit_y;
  logic                              out_zero_length;

  unit_result_t unit_expected [$];
  int           vectors_accepted = 0;
  int           mismatch_count = 0;
  int           recv_idle_pct = 84;
  logic         hold_off = 1'b0;

  vector2_normalize dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_x_component  (in_x_component),
    .in_y_component  (in_y_component),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_unit_x      (out_unit_x),
    .out_unit_y      (out_unit_y),
    .out_zero_length (out_zero_length)
  );

  always #HALF_PERIOD clk = ~clk;

  // largest q with q*q*len_sq <= m*m*2^28, applied with the sign of the component
  function automatic logic signed [v2n_pkg::COMP_W-1:0] component_unit(
      logic [v2n_pkg::MAG_W-1:0] m,
      logic [v2n_pkg::SUM_W-1:0] len_sq,
      logic                      neg);
    logic [63:0]                bound;
    logic [63:0]                trial;
    logic [v2n_pkg::Q_W-1:0]    q;
    logic [v2n_pkg::COMP_W-1:0] qv;
    bound = 64'(m) * 64'(m);
    bound = bound << (2 * v2n_pkg::FRAC_BITS);
    q = '0;
    for (int b = v2n_pkg::FRAC_BITS; b >= 0; b--) begin
      trial = 64'(q) | (64'd1 << b);
      if (trial * trial * 64'(len_sq) <= bound) q = v2n_pkg::Q_W'(trial);
    end
    qv = {1'b0, q};
    return neg ? v2n_pkg::COMP_W'(-qv) : qv;
  endfunction

  // exact unit vector of one input vector
  function automatic unit_result_t normalize_vector(logic signed [v2n_pkg::COMP_W-1:0] vx,
                                                    logic signed [v2n_pkg::COMP_W-1:0] vy);
    logic [v2n_pkg::MAG_W-1:0] mx;
    logic [v2n_pkg::MAG_W-1:0] my;
    logic [v2n_pkg::SUM_W-1:0] len_sq;
    unit_result_t              r;
    mx = vx[v2n_pkg::COMP_W-1] ? 17'h10000 - {1'b0, vx} : {1'b0, vx};
    my = vy[v2n_pkg::COMP_W-1] ? 17'h10000 - {1'b0, vy} : {1'b0, vy};
    len_sq = v2n_pkg::SUM_W'(mx) * v2n_pkg::SUM_W'(mx)
           + v2n_pkg::SUM_W'(my) * v2n_pkg::SUM_W'(my);
    if (len_sq == '0) begin
      r = '{16'sd0, 16'sd0, 1'b1};
    end else begin
      r.ux   = component_unit(mx, len_sq, vx[v2n_pkg::COMP_W-1]);
      r.uy   = component_unit(my, len_sq, vy[v2n_pkg::COMP_W-1]);
      r.zero = 1'b0;
    end
    return r;
  endfunction

  // one of the boundary values of a component
  function automatic logic signed [v2n_pkg::COMP_W-1:0] corner_value();
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return -16'sd1;
      2: return 16'sd0;
      3: return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  // receiver: random stall, forced high during the long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // long hold-off while the sender keeps offering, so the pipeline backs up
  initial begin
    wait (vectors_accepted >= N_DIR + 2 * PHASE_LEN + 20);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // result check against the oldest expectation, then record the input transfer
  always @(posedge clk) begin
    unit_result_t got;
    unit_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_unit_x, out_unit_y, out_zero_length};
        if (unit_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result transfer: unit_x=%0d unit_y=%0d zero_length=%0b",
                     got.ux, got.uy, got.zero);
        end else begin
          want = unit_expected.pop_front();
          if (got.ux !== want.ux || got.uy !== want.uy || got.zero !== want.zero) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("mismatch: expected (%0d, %0d, %0b) got (%0d, %0d, %0b)",
                       want.ux, want.uy, want.zero, got.ux, got.uy, got.zero);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (vectors_accepted < N_DIR && DIR_ROWS[vectors_accepted].known)
          unit_expected.push_back('{DIR_ROWS[vectors_accepted].ux,
                                    DIR_ROWS[vectors_accepted].uy,
                                    DIR_ROWS[vectors_accepted].zero});
        else
          unit_expected.push_back(normalize_vector(in_x_component, in_y_component));
        vectors_accepted <= vectors_accepted + 1;
      end
    end
  end

  // reset, stimulus, drain and verdict
  initial begin
    logic signed [v2n_pkg::COMP_W-1:0] nx;
    logic signed [v2n_pkg::COMP_W-1:0] ny;
    int                                send_pct;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_x_component <= '0;
    in_y_component <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int n = 0; n < N_DIR + N_RAND; n++) begin
      // idling phases: sender light / receiver heavy, then swapped, then none
      if (n < N_DIR + PHASE_LEN) begin
        send_pct = 11;
        recv_idle_pct <= 84;
      end else if (n < N_DIR + 2 * PHASE_LEN) begin
        send_pct = 84;
        recv_idle_pct <= 11;
      end else begin
        send_pct = 0;
        recv_idle_pct <= 0;
      end
      if (n < N_DIR) begin
        nx = DIR_ROWS[n].x;
        ny = DIR_ROWS[n].y;
      end else begin
        case ($urandom_range(0, 9))
          6: begin
            nx = v2n_pkg::COMP_W'($signed($urandom_range(0, 15)) - 8);
            ny = v2n_pkg::COMP_W'($signed($urandom_range(0, 15)) - 8);
          end
          7: begin
            nx = corner_value();
            ny = v2n_pkg::COMP_W'($urandom);
            if ($urandom_range(0, 1)) {nx, ny} = {ny, nx};
          end
          8: begin
            nx = corner_value();
            ny = corner_value();
          end
          9: begin
            nx = v2n_pkg::COMP_W'($urandom);
            ny = $urandom_range(0, 1) ? nx : -nx;
          end
          default: begin
            nx = v2n_pkg::COMP_W'($urandom);
            ny = v2n_pkg::COMP_W'($urandom);
          end
        endcase
      end
      // sender gaps
      while ($urandom_range(0, 99) < send_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid       <= 1'b1;
      in_x_component <= nx;
      in_y_component <= ny;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (unit_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
